### design/pidsc_pkg.sv
// pidsc_pkg: widths, register indexes and request codes of the pid step controller
// no dependencies; imported by pid_step_controller

package pidsc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int GAIN_W    = 32;
    localparam int HALF_W    = GAIN_W / 2;
    localparam int DIGIT_W   = HALF_W + 1;
    localparam int POS_W     = 32;
    localparam int DT_W      = 16;
    localparam int DRIVE_W   = 32;
    localparam int GAIN_FRAC = 24;
    localparam int DT_FRAC   = 16;

    localparam int IN_TDATA_W  = 2 * POS_W + DT_W;
    localparam int OUT_TDATA_W = DRIVE_W;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_P_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_I_GAIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_D_GAIN = 2'd2;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

endpackage

### design/pid_step_controller.sv
// pid_step_controller: discrete pid step on one shared multiply-accumulate unit and a
// radix-4 restoring divider, sequenced by a small state machine
// depends on pidsc_pkg
//
// usage:
//   configuration: cfg_wr_en / cfg_addr / cfg_wdata write p_gain (0), i_gain (1) and
//   d_gain (2), signed q8.24; other indexes are ignored. write only while idle.
//   input request: s_tuser carries the opcode (step or clear), s_tdata carries setpoint,
//   measured and time_step. one request is taken at a time; s_tready is high only while
//   the sequencer is idle.
//   result: m_tdata carries drive (signed q16.16), m_tuser carries the saturated flag.
//   sequence: a step request runs the p, i, time-step and d products on the multiplier,
//   then the divider loop (two quotient bits per cycle) over QW = 2*((VALUE_WIDTH+9)/2)
//   quotient bits, then the final sum; a zero time step or a derivative that saturates
//   skips the divider loop. a clear request goes straight to the final step.
//   the multiplier is one VALUE_WIDTH+8 by 17 bit unit used seven times per step.
//   stall: the result sits in an output register; the next request is accepted while it
//   waits, and its result is held back until m_tready frees the register.
//   reset: aresetn (synchronous, active low) clears gains, integral, previous error and
//   all handshake state.

module pid_step_controller
    import pidsc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [GAIN_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // setpoint, measured, time_step
    input  logic [0:0]             s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // drive
    output logic [0:0]             m_tuser    // saturated
);

    localparam int VW   = VALUE_WIDTH;
    localparam int AW   = VW + 8;
    localparam int PW   = AW + DIGIT_W;
    localparam int ACCW = PW + HALF_W;
    localparam int QMW  = VW + 9;
    localparam int QW   = 2 * ((VW + 9) / 2);
    localparam int NW   = QMW + DT_FRAC;
    localparam int HALF = QW / 2;
    localparam int CNTW = $clog2(HALF);
    localparam int DIFW = VW + POS_W + 2;
    localparam int SW   = VW + 9;
    localparam int TW   = QW + 3;

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_P_LO     = 4'd1;
    localparam logic [3:0] ST_P_HI     = 4'd2;
    localparam logic [3:0] ST_I_LO     = 4'd3;
    localparam logic [3:0] ST_I_HI     = 4'd4;
    localparam logic [3:0] ST_DT       = 4'd5;
    localparam logic [3:0] ST_D_LO     = 4'd6;
    localparam logic [3:0] ST_D_HI     = 4'd7;
    localparam logic [3:0] ST_DIV_INIT = 4'd8;
    localparam logic [3:0] ST_DIV      = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;

    logic [3:0]               state_reg, state_next;
    logic [GAIN_W-1:0]        p_gain_reg, p_gain_next;
    logic [GAIN_W-1:0]        i_gain_reg, i_gain_next;
    logic [GAIN_W-1:0]        d_gain_reg, d_gain_next;
    logic [VW-1:0]            integ_reg, integ_next;
    logic [VW-1:0]            prev_reg, prev_next;
    logic [VW-1:0]            err_reg, err_next;
    logic [VW:0]              delta_reg, delta_next;
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic                     clr_reg, clr_next;
    logic                     int_hit_reg, int_hit_next;
    logic [AW-1:0]            pterm_reg, pterm_next;
    logic [ACCW-1:0]          acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic                     dzero_reg, dzero_next;
    logic                     dsat_reg, dsat_next;
    logic [DT_W-1:0]          rem_reg, rem_next;
    logic [QW-1:0]            num_reg, num_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]       drive_reg, drive_next;
    logic                     sat_reg, sat_next;

    // input fields
    logic [POS_W-1:0] in_setpoint;
    logic [POS_W-1:0] in_measured;
    logic [DT_W-1:0]  in_dt;
    logic             in_fire;

    assign in_setpoint = s_tdata[POS_W-1:0];
    assign in_measured = s_tdata[2*POS_W-1:POS_W];
    assign in_dt       = s_tdata[2*POS_W +: DT_W];
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;

    // error with clipping to the value range
    logic [DIFW-1:0] diff;
    logic            diff_fits;
    logic [VW-1:0]   err_in;

    assign diff = {{(VW+2){in_setpoint[POS_W-1]}}, in_setpoint}
                - {{(VW+2){in_measured[POS_W-1]}}, in_measured};
    assign diff_fits = (&diff[DIFW-1:VW-1]) || !(|diff[DIFW-1:VW-1]);
    assign err_in = diff_fits ? diff[VW-1:0] : (diff[DIFW-1] ? VMIN : VMAX);

    // shared multiply-accumulate unit
    logic signed [AW-1:0]      mul_a;
    logic signed [DIGIT_W-1:0] mul_d;
    logic signed [PW-1:0]      prod;
    logic [ACCW-1:0]           addend;
    logic                      acc_en, acc_clr, acc_hi;

    assign prod   = mul_a * mul_d;
    assign addend = acc_hi ? {prod, {HALF_W{1'b0}}} : {{HALF_W{prod[PW-1]}}, prod};

    // integral update
    logic [AW-1:0] inc_w;
    logic [SW-1:0] isum;
    logic          isum_fits;
    logic [VW-1:0] isum_clip;

    assign inc_w     = acc_reg[DT_FRAC +: AW];
    assign isum      = {{(SW-VW){integ_reg[VW-1]}}, integ_reg}
                     + {{(SW-AW){inc_w[AW-1]}}, inc_w};
    assign isum_fits = (&isum[SW-1:VW-1]) || !(|isum[SW-1:VW-1]);
    assign isum_clip = isum_fits ? isum[VW-1:0] : (isum[SW-1] ? VMIN : VMAX);

    // divider setup: magnitude of the scaled derivative product
    logic [QMW-1:0]  dq;
    logic [QMW-1:0]  dmag_in;
    logic [NW-1:0]   num_full;
    logic [DT_W:0]   num_hi;
    logic [DT_W:0]   dt_ext;

    assign dq       = acc_reg[GAIN_FRAC +: QMW];
    assign dmag_in  = dq[QMW-1] ? (~dq + 1'b1) : dq;
    assign num_full = {dmag_in, {DT_FRAC{1'b0}}};
    assign num_hi   = (DT_W+1)'(dmag_in >> (QW - DT_FRAC));
    assign dt_ext   = {1'b0, dt_reg};

    // two restoring steps per cycle
    logic [DT_W:0] r1, r1s, r2, r2s;
    logic          ge1, ge2;

    assign r1  = {rem_reg, num_reg[QW-1]};
    assign ge1 = (r1 >= dt_ext);
    assign r1s = ge1 ? (r1 - dt_ext) : r1;
    assign r2  = {r1s[DT_W-1:0], num_reg[QW-2]};
    assign ge2 = (r2 >= dt_ext);
    assign r2s = ge2 ? (r2 - dt_ext) : r2;

    // final sum and saturation
    logic [QW-1:0]  dterm_mag;
    logic [QW:0]    dterm;
    logic [TW-1:0]  total;
    logic           total_fits;
    logic [VW-1:0]  total_clip;
    logic [VW+DRIVE_W-1:0] drive_ext;

    assign dterm_mag  = dzero_reg ? '0 : (dsat_reg ? '1 : num_reg);
    assign dterm      = neg_reg ? (~{1'b0, dterm_mag} + 1'b1) : {1'b0, dterm_mag};
    assign total      = {{(TW-AW){pterm_reg[AW-1]}}, pterm_reg}
                      + {{(TW-VW){integ_reg[VW-1]}}, integ_reg}
                      + {{(TW-QW-1){dterm[QW]}}, dterm};
    assign total_fits = (&total[TW-1:VW-1]) || !(|total[TW-1:VW-1]);
    assign total_clip = total_fits ? total[VW-1:0] : (total[TW-1] ? VMIN : VMAX);
    assign drive_ext  = {{DRIVE_W{total_clip[VW-1]}}, total_clip};

    always_comb begin
        state_next     = state_reg;
        p_gain_next    = p_gain_reg;
        i_gain_next    = i_gain_reg;
        d_gain_next    = d_gain_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        delta_next     = delta_reg;
        dt_next        = dt_reg;
        clr_next       = clr_reg;
        int_hit_next   = int_hit_reg;
        pterm_next     = pterm_reg;
        neg_next       = neg_reg;
        dzero_next     = dzero_reg;
        dsat_next      = dsat_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        drive_next     = drive_reg;
        sat_next       = sat_reg;
        mul_a          = {{(AW-VW){err_reg[VW-1]}}, err_reg};
        mul_d          = '0;
        acc_en         = 1'b0;
        acc_clr        = 1'b0;
        acc_hi         = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_P_GAIN: p_gain_next = cfg_wdata;
                REG_I_GAIN: i_gain_next = cfg_wdata;
                REG_D_GAIN: d_gain_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    clr_next = (s_tuser[0] == OP_CLEAR);
                    if (s_tuser[0] == OP_CLEAR) begin
                        integ_next = '0;
                        prev_next  = '0;
                        state_next = ST_FIN;
                    end else begin
                        err_next     = err_in;
                        dt_next      = in_dt;
                        int_hit_next = 1'b0;
                        state_next   = ST_P_LO;
                    end
                end
            end
            ST_P_LO: begin
                delta_next = {err_reg[VW-1], err_reg} - {prev_reg[VW-1], prev_reg};
                prev_next  = err_reg;
                mul_d      = {1'b0, p_gain_reg[HALF_W-1:0]};
                acc_en     = 1'b1;
                acc_clr    = 1'b1;
                state_next = ST_P_HI;
            end
            ST_P_HI: begin
                mul_d      = {p_gain_reg[GAIN_W-1], p_gain_reg[GAIN_W-1 -: HALF_W]};
                acc_en     = 1'b1;
                acc_hi     = 1'b1;
                state_next = ST_I_LO;
            end
            ST_I_LO: begin
                pterm_next = acc_reg[GAIN_FRAC +: AW];
                mul_d      = {1'b0, i_gain_reg[HALF_W-1:0]};
                acc_en     = 1'b1;
                acc_clr    = 1'b1;
                state_next = ST_I_HI;
            end
            ST_I_HI: begin
                mul_d      = {i_gain_reg[GAIN_W-1], i_gain_reg[GAIN_W-1 -: HALF_W]};
                acc_en     = 1'b1;
                acc_hi     = 1'b1;
                state_next = ST_DT;
            end
            ST_DT: begin
                mul_a      = acc_reg[GAIN_FRAC +: AW];
                mul_d      = {1'b0, dt_reg};
                acc_en     = 1'b1;
                acc_clr    = 1'b1;
                state_next = ST_D_LO;
            end
            ST_D_LO: begin
                integ_next   = isum_clip;
                int_hit_next = !isum_fits;
                mul_a        = {{(AW-VW-1){delta_reg[VW]}}, delta_reg};
                mul_d        = {1'b0, d_gain_reg[HALF_W-1:0]};
                acc_en       = 1'b1;
                acc_clr      = 1'b1;
                state_next   = ST_D_HI;
            end
            ST_D_HI: begin
                mul_a      = {{(AW-VW-1){delta_reg[VW]}}, delta_reg};
                mul_d      = {d_gain_reg[GAIN_W-1], d_gain_reg[GAIN_W-1 -: HALF_W]};
                acc_en     = 1'b1;
                acc_hi     = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                neg_next   = dq[QMW-1];
                dzero_next = (dt_reg == '0);
                dsat_next  = (num_hi >= dt_ext);
                rem_next   = num_hi[DT_W-1:0];
                num_next   = num_full[QW-1:0];
                cnt_next   = CNTW'(HALF - 1);
                if ((dt_reg == '0) || (num_hi >= dt_ext)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = r2s[DT_W-1:0];
                num_next = {num_reg[QW-3:0], ge1, ge2};
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    drive_next     = clr_reg ? '0 : drive_ext[DRIVE_W-1:0];
                    sat_next       = !clr_reg && (int_hit_reg || !total_fits);
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (!acc_en) begin
            acc_next = acc_reg;
        end else if (acc_clr) begin
            acc_next = addend;
        end else begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            p_gain_reg    <= '0;
            i_gain_reg    <= '0;
            d_gain_reg    <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            clr_reg       <= 1'b0;
            int_hit_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            p_gain_reg    <= p_gain_next;
            i_gain_reg    <= i_gain_next;
            d_gain_reg    <= d_gain_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            clr_reg       <= clr_next;
            int_hit_reg   <= int_hit_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg   <= err_next;
        delta_reg <= delta_next;
        dt_reg    <= dt_next;
        pterm_reg <= pterm_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        dzero_reg <= dzero_next;
        dsat_reg  <= dsat_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        drive_reg <= drive_next;
        sat_reg   <= sat_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = sat_reg;

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < dt_reg)
        else $error("divider remainder out of range");

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_CLEAR) |=> integ_reg == '0 && prev_reg == '0)
        else $error("clear request left integral or previous error");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside final step");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && clr_reg && (!m_tvalid || m_tready)
        |=> m_tdata == '0 && m_tuser == 1'b0)
        else $error("clear request gave nonzero result");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench for pid_step_controller: queued step and clear requests against an in-bench
// fixed-point pid predictor, with random handshake gaps and several gain settings
// depends on pidsc_pkg and pid_step_controller

module testbench;
    import pidsc_pkg::*;

    localparam int VALUE_W = VALUE_WIDTH_DEF;
    localparam longint VAL_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam longint TERM_LIM = longint'(1) << 61;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BLOCK_ITEMS = 220;

    typedef struct packed {
        logic             opcode;
        logic [POS_W-1:0] setpoint;
        logic [POS_W-1:0] measured;
        logic [DT_W-1:0]  time_step;
    } pid_req_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               saturated;
    } pid_res_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [GAIN_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;  // setpoint, measured, time_step
    logic [0:0]             s_tuser = '0;  // opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;       // drive
    logic [0:0]             m_tuser;       // saturated

    pid_req_t step_queue[$];
    pid_res_t pending_drives[$];
    pid_req_t in_flight;
    pid_res_t want_res;

    longint kp_q24 = 0, ki_q24 = 0, kd_q24 = 0;
    longint integ_acc = 0, last_err = 0;

    int send_idle = 0, recv_idle = 0;
    int stall_asks = 0, stall_done = 0, hold_left = 0;
    int quiet_cycles = 0, mismatches = 0;
    int n_requests = 0, n_clears = 0, n_results = 0, n_sat = 0, n_settings = 0;

    pid_step_controller #(.VALUE_WIDTH(VALUE_W)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint clamp_value(longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    // floor(a*b / 2^sh), magnitude limited to 2^61
    function automatic longint mul_floor(longint a, longint b, int sh);
        logic signed [127:0] wa, wb, prod;
        wa = a;
        wb = b;
        prod = (wa * wb) >>> sh;
        if (prod > TERM_LIM) return TERM_LIM;
        if (prod < -TERM_LIM) return -TERM_LIM;
        return longint'(prod);
    endfunction

    // q * 2^16 / dt truncated toward zero, magnitude limited to 2^61
    function automatic longint div_by_dt(longint q, logic [DT_W-1:0] dt);
        logic [127:0] num;
        longint mag_q, res;
        mag_q = (q < 0) ? -q : q;
        num = 128'(mag_q) << DT_FRAC;
        num = num / dt;
        if (num > 128'(TERM_LIM)) num = 128'(TERM_LIM);
        res = longint'(num[63:0]);
        return (q < 0) ? -res : res;
    endfunction

    function automatic pid_res_t predict_drive(pid_req_t rq);
        longint err, pterm, inc, dterm, total, drive;
        logic hit;
        pid_res_t res;
        hit = 1'b0;
        if (rq.opcode == OP_CLEAR) begin
            integ_acc = 0;
            last_err = 0;
            res.drive = '0;
            res.saturated = 1'b0;
            return res;
        end
        err = clamp_value(longint'($signed(rq.setpoint)) - longint'($signed(rq.measured)));
        pterm = mul_floor(kp_q24, err, GAIN_FRAC);
        inc = mul_floor(mul_floor(ki_q24, err, GAIN_FRAC), longint'(rq.time_step), DT_FRAC);
        total = integ_acc + inc;
        integ_acc = clamp_value(total);
        if (integ_acc != total) hit = 1'b1;
        if (rq.time_step == '0) dterm = 0;
        else dterm = div_by_dt(mul_floor(kd_q24, err - last_err, GAIN_FRAC), rq.time_step);
        last_err = err;
        total = pterm + integ_acc + dterm;
        drive = clamp_value(total);
        if (drive != total) hit = 1'b1;
        res.drive = drive[DRIVE_W-1:0];
        res.saturated = hit;
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_drives.push_back(predict_drive(in_flight));
                n_requests++;
                if (in_flight.opcode == OP_CLEAR) n_clears++;
            end
            if (!s_tvalid || s_tready) begin
                if (step_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_flight = step_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {in_flight.time_step, in_flight.measured, in_flight.setpoint};
                    s_tuser <= in_flight.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and result check
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tuser[0]) n_sat++;
                if (pending_drives.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: drive=%h saturated=%b", m_tdata, m_tuser);
                end else begin
                    want_res = pending_drives.pop_front();
                    if (m_tdata !== want_res.drive || m_tuser[0] !== want_res.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at result %0d: drive exp %h got %h, saturated exp %b got %b",
                                     n_results, want_res.drive, m_tdata,
                                     want_res.saturated, m_tuser);
                    end
                end
            end
            if (stall_asks != stall_done) begin
                stall_done++;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic op, input logic [31:0] sp, input logic [31:0] ms,
                            input logic [DT_W-1:0] dt);
        pid_req_t rq;
        rq.opcode = op;
        rq.setpoint = sp;
        rq.measured = ms;
        rq.time_step = dt;
        step_queue.push_back(rq);
    endtask

    // checked between edges so that driver and monitor updates have settled
    task automatic settle();
        while (!(step_queue.size() == 0 && !s_tvalid && pending_drives.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
    endtask

    task automatic set_gains(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d);
        write_gain(REG_P_GAIN, p);
        write_gain(REG_I_GAIN, i);
        write_gain(REG_D_GAIN, d);
        write_gain(REG_UNUSED, $urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        kp_q24 = longint'($signed(p));
        ki_q24 = longint'($signed(i));
        kd_q24 = longint'($signed(d));
        n_settings++;
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(9))
            0: return '0;
            1: return POS_MIN;
            2: return POS_MAX;
            3, 4: return $urandom;
            default: begin
                g = $urandom_range(32'h0400_0000);
                return $urandom_range(1) ? -g : g;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_position();
        case ($urandom_range(9))
            0: return POS_MAX;
            1: return POS_MIN;
            2, 3: return $urandom;
            default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 16'd1;
            3, 4: return DT_W'($urandom);
            default: return DT_W'($urandom_range(2000, 16));
        endcase
    endfunction

    // runs of steps that track a drifting target, most of them opened by a clear
    task automatic gen_block(input int count);
        int left, run, k;
        logic [31:0] target, meas;
        left = count;
        while (left > 0) begin
            if ($urandom_range(9) < 7) begin
                push_req(OP_CLEAR, $urandom, $urandom, DT_W'($urandom));
                left--;
            end
            run = $urandom_range(40, 4);
            target = pick_position();
            for (k = 0; k < run && left > 0; k++) begin
                if ($urandom_range(9) == 0) target = pick_position();
                else target = target + $urandom_range(4096) - 2048;
                if ($urandom_range(4) == 0) meas = pick_position();
                else meas = target + $urandom_range(32'h0004_0000) - 32'h0002_0000;
                push_req(OP_STEP, target, meas, pick_dt());
                left--;
            end
        end
    endtask

    initial begin
        int phase, sub, k;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 12;
        recv_idle = 57;

        // gains still at reset
        push_req(OP_STEP, POS_MAX, POS_MIN, '1);
        push_req(OP_STEP, ONE_Q16, 32'd0, 16'd1);
        settle();

        set_gains(32'h0100_0000, 32'h0080_0000, 32'h0020_0000);
        push_req(OP_CLEAR, $urandom, $urandom, DT_W'($urandom));
        push_req(OP_STEP, 32'd0, 32'd0, '0);
        push_req(OP_STEP, ONE_Q16, 32'd0, 16'h0100);
        push_req(OP_STEP, ONE_Q16, ONE_Q16 >> 1, '0);
        push_req(OP_STEP, POS_MAX, POS_MIN, '1);
        push_req(OP_STEP, POS_MIN, POS_MAX, 16'd1);
        push_req(OP_STEP, POS_MIN, POS_MIN, '1);
        for (k = 0; k < 4; k++) push_req(OP_STEP, POS_MAX, 32'd0, '1);
        push_req(OP_CLEAR, '1, '1, '1);
        for (k = 0; k < 3; k++) push_req(OP_STEP, POS_MIN, 32'd0, '1);
        push_req(OP_STEP, 32'd0, 32'd0, 16'd1);
        settle();

        set_gains(POS_MAX, POS_MIN, POS_MAX);
        push_req(OP_CLEAR, 32'd0, 32'd0, '0);
        push_req(OP_STEP, ONE_Q16, -ONE_Q16, 16'd1);
        push_req(OP_STEP, -ONE_Q16, ONE_Q16, '1);
        push_req(OP_STEP, 32'd1, 32'd0, '1);
        push_req(OP_STEP, '1, 32'd0, 16'd1);
        push_req(OP_STEP, 32'd0, 32'd0, '0);
        settle();

        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 12 : (phase == 1) ? 57 : 0;
            recv_idle = (phase == 0) ? 57 : (phase == 1) ? 12 : 0;
            for (sub = 0; sub < 3; sub++) begin
                set_gains(pick_gain(), pick_gain(), pick_gain());
                gen_block(BLOCK_ITEMS);
                // receiver backs off while the queue is still full
                if (sub == 0) stall_asks++;
                settle();
            end
        end

        $display("covered %0d requests (%0d clears) over %0d gain settings",
                 n_requests, n_clears, n_settings);
        $display("checked %0d results, %0d saturated, %0d mismatches",
                 n_results, n_sat, mismatches);
        if (mismatches == 0 && pending_drives.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
